[rtl/core/ppd_pkg.sv]
// Shared types, constants and the helper function of the position PD controller.
`default_nettype none

package ppd_pkg;

    localparam int AngleW   = 32;
    localparam int WordW    = 16;
    localparam int CfgIdxW  = 4;
    localparam int QShift   = 12;
    localparam int ProdW    = 2 * WordW;
    localparam int TermW    = ProdW - QShift;
    localparam int SumW     = TermW + 1;
    localparam int DiffW    = AngleW + 1;

    localparam logic signed [WordW-1:0] ErrLimit = 16'sd32767;
    localparam logic signed [WordW-1:0] Deadband = 16'sd10;

    localparam logic signed [WordW-1:0] ResetPropGain  = 16'sd0;
    localparam logic signed [WordW-1:0] ResetDerivGain = 16'sd0;
    localparam logic signed [WordW-1:0] ResetOutMax    = 16'sh7fff;
    localparam logic signed [WordW-1:0] ResetOutMin    = 16'sh8000;

    typedef logic signed [AngleW-1:0] t_angle;
    typedef logic signed [WordW-1:0]  t_word;
    typedef logic signed [TermW-1:0]  t_term;
    typedef logic signed [SumW-1:0]   t_sum;
    typedef logic        [CfgIdxW-1:0] t_cfg_index;

    typedef enum logic [CfgIdxW-1:0] {
        CfgPropGain  = 4'd0,
        CfgDerivGain = 4'd1,
        CfgOutMax    = 4'd2,
        CfgOutMin    = 4'd3
    } t_cfg_reg;

    typedef struct packed {
        t_word prop_gain;
        t_word deriv_gain;
        t_word out_max;
        t_word out_min;
    } t_cfg;

    // Full-precision angle difference, saturated to the error range, then the deadband.
    function automatic t_word sat_deadband(input t_angle tgt, input t_angle sen);
        logic signed [DiffW-1:0] diff;
        t_word                   sat;
        diff = {tgt[AngleW-1], tgt} - {sen[AngleW-1], sen};
        if (diff > DiffW'(ErrLimit)) begin
            sat = ErrLimit;
        end else if (diff < -DiffW'(ErrLimit)) begin
            sat = -ErrLimit;
        end else begin
            sat = diff[WordW-1:0];
        end
        if (sat <= Deadband && sat >= -Deadband) begin
            sat = '0;
        end
        return sat;
    endfunction

endpackage

`default_nettype wire

[rtl/core/ppd_cmd_if.sv]
// Handshake channel carrying one position tick: target and sensor angles.
`default_nettype none

interface ppd_cmd_if;
    logic            valid;
    logic            ready;
    ppd_pkg::t_angle target_angle;
    ppd_pkg::t_angle sensor_angle;

    modport source (output valid, output target_angle, output sensor_angle, input ready);
    modport sink   (input valid, input target_angle, input sensor_angle, output ready);
endinterface

`default_nettype wire

[rtl/core/ppd_res_if.sv]
// Handshake channel carrying one result: speed reference and stored error.
`default_nettype none

interface ppd_res_if;
    logic           valid;
    logic           ready;
    ppd_pkg::t_word speed_ref;
    ppd_pkg::t_word pos_error;

    modport source (output valid, output speed_ref, output pos_error, input ready);
    modport sink   (input valid, input speed_ref, input pos_error, output ready);
endinterface

`default_nettype wire

[rtl/core/ppd_cfg_if.sv]
// Configuration write channel carrying a register index and write data.
`default_nettype none

interface ppd_cfg_if;
    logic                valid;
    logic                ready;
    ppd_pkg::t_cfg_index index;
    ppd_pkg::t_word      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/position_pd_controller.sv]
// Top level of the position PD controller with deadband and output clamp.
//
// Usage: each item on i_cmd is one position-loop tick with a target and a
// sensor angle. The block returns exactly one item on o_res per tick: the
// clamped speed reference and the error after saturation and deadband.
// Gains and limits are written through i_cfg, one register per item; the user
// must write them only while the block is idle, as the block does not enforce
// this. i_cfg is always ready and unknown indexes are ignored. The input
// register loads at the accepting edge, then the error, product and result
// registers follow in order. One item is taken every cycle while the receiver
// does not stall; the only feedback is the stored previous error, updated in
// the error stage. Reset empties the pipeline, clears the previous error and
// loads the default gains and limits. When the receiver stalls, the pipeline
// fills up and i_cmd.ready falls only once every stage holds an item.
`default_nettype none

module position_pd_controller (
    input  wire     i_clk,
    input  wire     i_rst_n,
    ppd_cmd_if.sink i_cmd,
    ppd_cfg_if.sink i_cfg,
    ppd_res_if.source o_res
);
    import ppd_pkg::*;

    t_cfg cfg;

    logic  r_v1, r_v2, r_v3, r_v4;
    logic  adv1, adv2, adv3, adv4;
    t_angle r_tgt, r_sen;
    t_word r_err2, r_dlt2, r_err3, r_err4, r_speed4, r_prev_error;
    t_term r_pterm3, r_dterm3;

    t_word                    n_err;
    t_word                    n_dlt;
    logic signed [ProdW-1:0]  n_pprod;
    logic signed [ProdW-1:0]  n_dprod;
    t_sum                     n_sum;
    t_word                    n_speed;

    ppd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    assign adv4 = !r_v4 || o_res.ready;
    assign adv3 = !r_v3 || adv4;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign i_cmd.ready = adv1;

    always_comb begin
        n_err   = sat_deadband(r_tgt, r_sen);
        n_dlt   = n_err - r_prev_error;
        n_pprod = ProdW'(cfg.prop_gain) * ProdW'(r_err2);
        n_dprod = ProdW'(cfg.deriv_gain) * ProdW'(r_dlt2);
        n_sum   = {r_pterm3[TermW-1], r_pterm3} + {r_dterm3[TermW-1], r_dterm3};
        if (n_sum > SumW'(cfg.out_max)) begin
            n_speed = cfg.out_max;
        end else if (n_sum < SumW'(cfg.out_min)) begin
            n_speed = cfg.out_min;
        end else begin
            n_speed = n_sum[WordW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_v4         <= 1'b0;
            r_prev_error <= '0;
        end else begin
            if (adv1) begin
                r_v1 <= i_cmd.valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
                if (r_v1) begin
                    r_prev_error <= n_err;
                end
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
            if (adv4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv1 && i_cmd.valid) begin
            r_tgt <= i_cmd.target_angle;
            r_sen <= i_cmd.sensor_angle;
        end
        if (adv2 && r_v1) begin
            r_err2 <= n_err;
            r_dlt2 <= n_dlt;
        end
        if (adv3 && r_v2) begin
            r_pterm3 <= n_pprod[ProdW-1:QShift];
            r_dterm3 <= n_dprod[ProdW-1:QShift];
            r_err3   <= r_err2;
        end
        if (adv4 && r_v3) begin
            r_speed4 <= n_speed;
            r_err4   <= r_err3;
        end
    end

    assign o_res.valid     = r_v4;
    assign o_res.speed_ref = r_speed4;
    assign o_res.pos_error = r_err4;

    a_speed_in_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v4 && cfg.out_min <= cfg.out_max) |->
            (r_speed4 >= cfg.out_min && r_speed4 <= cfg.out_max))
        else $error("speed reference outside the configured limits");

    a_error_deadband: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_err4 == '0 || r_err4 > Deadband || r_err4 < -Deadband))
        else $error("stored error lies inside the deadband");

    a_error_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v4 |-> (r_err4 >= -ErrLimit))
        else $error("stored error below the saturation limit");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v4 |-> i_cmd.ready)
        else $error("input stalled while the result register is empty");

    a_prev_error_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv2 && r_v1) |=> (r_prev_error == r_err2))
        else $error("previous error not taken from the error stage");

endmodule

`default_nettype wire

[rtl/core/ppd_cfg_regs.sv]
// Configuration register file holding the gains and the output limits.
`default_nettype none

module ppd_cfg_regs (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ppd_cfg_if.sink      i_cfg,
    output ppd_pkg::t_cfg o_cfg
);
    import ppd_pkg::*;

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= ResetPropGain;
            r_cfg.deriv_gain <= ResetDerivGain;
            r_cfg.out_max    <= ResetOutMax;
            r_cfg.out_min    <= ResetOutMin;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CfgPropGain:  r_cfg.prop_gain  <= i_cfg.data;
                CfgDerivGain: r_cfg.deriv_gain <= i_cfg.data;
                CfgOutMax:    r_cfg.out_max    <= i_cfg.data;
                CfgOutMin:    r_cfg.out_min    <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
